FILE: src/gbl_pkg.sv
// Shared constants, types and helpers of the 5x5 Gaussian blur.
// Used by gbl_cell, gbl_outq and gaussian_blur_5x5; depends on nothing.
package gbl_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int KSIZE      = 5;
    localparam int HALF       = KSIZE / 2;
    localparam int LINES      = KSIZE - 1;

    localparam int PIX_W  = 8;
    localparam int WGT_W  = 4;
    localparam int CFG_W  = 12;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
    localparam int OROW_W = $clog2(MAX_HEIGHT);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + HALF + 1);
    localparam int LAG_W  = $clog2(HALF * (MAX_WIDTH + 1) + 1);
    localparam int LINE_W = $clog2(LINES);

    // Kernel sum is at most 255*159, so 16 bits hold any partial sum.
    localparam int DIVISOR     = 159;
    localparam int PSUM_W      = 16;
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP       = (2 ** RECIP_SHIFT + DIVISOR - 1) / DIVISOR;
    localparam int PROD_W      = PSUM_W + $clog2(RECIP + 1);

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Register select, taken from the word address bit
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix [KSIZE-1:0] t_col;
    typedef logic [KSIZE-1:0][WGT_W-1:0] t_wcol;

    typedef struct packed {
        logic last;
        t_pix pix;
    } t_res;

    // Column weights; the kernel is symmetric, so column k equals row k.
    localparam t_wcol KWEIGHT [KSIZE] = '{
        {4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
        {4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        {4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
        {4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        {4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
    };

    // Saturate a written size to the range KSIZE..vmax.
    function automatic int f_clamp(logic [CFG_W-1:0] v, int vmax);
        int r;
        r = int'(v);
        if (r < KSIZE) r = KSIZE;
        if (r > vmax) r = vmax;
        return r;
    endfunction

endpackage

FILE: src/gbl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Reads return the old contents when the same address is written in that cycle.
module gbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/gbl_cell.sv
// One column cell of the blur chain: weights the incoming column and adds the
// partial sum handed over by its left neighbor. Depends on gbl_pkg.
module gbl_cell (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  gbl_pkg::t_col                i_col,
    input  gbl_pkg::t_wcol               i_wgt,
    input  logic [gbl_pkg::PSUM_W-1:0]   i_psum,
    output logic [gbl_pkg::PSUM_W-1:0]   o_psum
);

    logic [gbl_pkg::PSUM_W-1:0] w_dot;
    logic [gbl_pkg::PSUM_W-1:0] n_psum;
    logic [gbl_pkg::PSUM_W-1:0] r_psum;

    always_comb begin
        w_dot = '0;
        for (int i = 0; i < gbl_pkg::KSIZE; i++) begin
            w_dot = w_dot + gbl_pkg::PSUM_W'(i_wgt[i]) * gbl_pkg::PSUM_W'(i_col[i]);
        end
        n_psum = i_psum + w_dot;
    end

    // advance only on a window step
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_psum <= n_psum;
        end
    end

    assign o_psum = r_psum;

endmodule

FILE: src/gbl_outq.sv
// Two-beat output buffer between the blur pipeline and the master stream.
// Full flag is registered so the pipeline never waits on the sink's ready.
module gbl_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gbl_pkg::t_res i_data,
    output logic          o_full,
    output logic          o_valid,
    output gbl_pkg::t_res o_data,
    input  logic          i_ready
);

    gbl_pkg::t_res r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    logic          w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        unique case ({i_push, w_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: src/gaussian_blur_5x5.sv
// Streaming 5x5 Gaussian blur (sigma 1.4) of 8-bit pixels in raster order.
// Throughput: one beat per cycle in each direction while the output buffer has room;
// four line-store banks are read and one written in the same cycle, and the window is a
// chain of five column cells. Results pass registered stages B, C and D into the output
// buffer; in stream order each result trails its input pixel by 2*width+2 beats.
// Reset: synchronous, active low; counters, valid flags and sizes (640x480) are set,
// the line store is not cleared (no clearing pass).
module gaussian_blur_5x5 (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] pixel_in
    input  logic [0:0]                   s_axis_tuser,   // [0] kind (1 = drain beat)
    // output stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,   // [7:0] pixel_out
    output logic                         m_axis_tlast,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gbl_pkg::APB_AW-1:0]   paddr,
    input  logic [gbl_pkg::APB_DW-1:0]   pwdata,
    output logic [gbl_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int KSIZE  = gbl_pkg::KSIZE;
    localparam int HALF   = gbl_pkg::HALF;
    localparam int LINES  = gbl_pkg::LINES;
    localparam int COL_W  = gbl_pkg::COL_W;
    localparam int ROW_W  = gbl_pkg::ROW_W;
    localparam int OROW_W = gbl_pkg::OROW_W;
    localparam int WDIM_W = gbl_pkg::WDIM_W;
    localparam int HDIM_W = gbl_pkg::HDIM_W;
    localparam int LAG_W  = gbl_pkg::LAG_W;
    localparam int LINE_W = gbl_pkg::LINE_W;
    localparam int CFG_W  = gbl_pkg::CFG_W;
    localparam int PSUM_W = gbl_pkg::PSUM_W;
    localparam int PROD_W = gbl_pkg::PROD_W;

    // ------------------------------------------------------------------
    // Configuration registers: raw value for read-back, clamped size for use
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  r_cfg_w;
    logic [CFG_W-1:0]  r_cfg_h;
    logic [WDIM_W-1:0] r_eff_w;
    logic [HDIM_W-1:0] r_eff_h;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == gbl_pkg::REG_HEIGHT) ?
                      gbl_pkg::APB_DW'(r_cfg_h) : gbl_pkg::APB_DW'(r_cfg_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_W'(gbl_pkg::RESET_WIDTH);
            r_cfg_h <= CFG_W'(gbl_pkg::RESET_HEIGHT);
            r_eff_w <= WDIM_W'(gbl_pkg::RESET_WIDTH);
            r_eff_h <= HDIM_W'(gbl_pkg::RESET_HEIGHT);
        end else if (w_cfg_wr) begin
            if (paddr[2] == gbl_pkg::REG_HEIGHT) begin
                r_cfg_h <= pwdata[CFG_W-1:0];
                r_eff_h <= HDIM_W'(gbl_pkg::f_clamp(pwdata[CFG_W-1:0], gbl_pkg::MAX_HEIGHT));
            end else begin
                r_cfg_w <= pwdata[CFG_W-1:0];
                r_eff_w <= WDIM_W'(gbl_pkg::f_clamp(pwdata[CFG_W-1:0], gbl_pkg::MAX_WIDTH));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: accept, position counters, line-store access
    // ------------------------------------------------------------------
    logic [COL_W-1:0]  r_col;    // input column; keeps running over virtual rows while draining
    logic [ROW_W-1:0]  r_row;
    logic [LAG_W-1:0]  r_fill;   // pixels taken before results start, saturates at lag
    logic              r_drain;  // whole image received: every beat now yields a result
    logic [COL_W-1:0]  r_ocol;   // position of the next result
    logic [OROW_W-1:0] r_orow;

    logic              w_adv;
    logic              w_acc;
    logic              w_pix_item;
    logic              w_step;
    logic              w_emit;
    logic              w_wr;
    logic [LAG_W-1:0]  w_lag;
    logic              w_col_end;
    logic              w_row_end;
    logic              w_ocol_end;
    logic              w_last;
    logic              w_border;

    logic              q_full;

    logic              r_b_step;
    logic              r_b_emit;
    logic              r_b_border;
    logic              r_b_last;
    logic [LINE_W-1:0] r_b_rot;
    gbl_pkg::t_pix     r_b_px;

    logic              r_c_emit;
    logic              r_c_border;
    logic              r_c_last;

    logic              r_d_valid;
    gbl_pkg::t_res     r_d_res;

    // Whole pipeline moves together; it holds only when a finished result
    // cannot enter the output buffer.
    assign w_adv         = !r_d_valid || !q_full;
    assign s_axis_tready = w_adv;
    assign w_acc         = s_axis_tvalid && w_adv;
    assign w_pix_item    = !s_axis_tuser[0];

    assign w_lag      = LAG_W'(HALF) * (LAG_W'(r_eff_w) + LAG_W'(1));
    assign w_col_end  = (WDIM_W'(r_col) == r_eff_w - WDIM_W'(1));
    assign w_row_end  = (r_row == ROW_W'(r_eff_h) - ROW_W'(1));
    assign w_ocol_end = (WDIM_W'(r_ocol) == r_eff_w - WDIM_W'(1));
    assign w_last     = w_ocol_end && (HDIM_W'(r_orow) == r_eff_h - HDIM_W'(1));
    assign w_border   = (r_orow < OROW_W'(HALF)) ||
                        (HDIM_W'(r_orow) >= r_eff_h - HDIM_W'(HALF)) ||
                        (r_ocol < COL_W'(HALF)) ||
                        (WDIM_W'(r_ocol) >= r_eff_w - WDIM_W'(HALF));

    // A drain beat before the image is complete does nothing; after it, any
    // beat shifts the window on and gives one result, and its sample is dropped.
    assign w_step = w_acc && (r_drain || w_pix_item);
    assign w_wr   = w_acc && !r_drain && w_pix_item;
    assign w_emit = w_acc && (r_drain || (w_pix_item && (r_fill == w_lag)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_fill  <= '0;
            r_drain <= 1'b0;
            r_ocol  <= '0;
            r_orow  <= '0;
        end else if (w_cfg_wr) begin
            // a size change aborts any image in progress
            r_col   <= '0;
            r_row   <= '0;
            r_fill  <= '0;
            r_drain <= 1'b0;
            r_ocol  <= '0;
            r_orow  <= '0;
        end else begin
            if (w_step) begin
                if (w_col_end) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_W'(1);
                    if (!r_drain && w_row_end) r_drain <= 1'b1;
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            if (w_wr && (r_fill != w_lag)) begin
                r_fill <= r_fill + LAG_W'(1);
            end
            if (w_emit) begin
                if (w_last) begin
                    // final result given: start over for the next image
                    r_col   <= '0;
                    r_row   <= '0;
                    r_fill  <= '0;
                    r_drain <= 1'b0;
                    r_ocol  <= '0;
                    r_orow  <= '0;
                end else if (w_ocol_end) begin
                    r_ocol <= '0;
                    r_orow <= r_orow + OROW_W'(1);
                end else begin
                    r_ocol <= r_ocol + COL_W'(1);
                end
            end
        end
    end

    // Four line banks; the row number picks the bank written, and a read of
    // the same bank and column returns the line from four rows back.
    gbl_pkg::t_pix w_ram_rd [LINES];

    for (genvar b = 0; b < LINES; b++) begin : g_line
        gbl_ram #(
            .WIDTH (gbl_pkg::PIX_W),
            .DEPTH (gbl_pkg::MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (w_wr && (r_row[LINE_W-1:0] == LINE_W'(b))),
            .i_waddr (r_col),
            .i_wdata (s_axis_tdata),
            .i_re    (w_step),
            .i_raddr (r_col),
            .o_rdata (w_ram_rd[b])
        );
    end

    // ------------------------------------------------------------------
    // Stage B: line data arrives; assemble the new window column
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_step <= 1'b0;
            r_b_emit <= 1'b0;
            r_c_emit <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_step  <= w_step;
            r_b_emit  <= w_emit;
            r_c_emit  <= r_b_emit;
            r_d_valid <= r_c_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_border <= w_border;
            r_b_last   <= w_last;
            r_b_rot    <= r_row[LINE_W-1:0];
            r_b_px     <= s_axis_tdata;
            r_c_border <= r_b_border;
            r_c_last   <= r_b_last;
        end
    end

    gbl_pkg::t_col w_col;

    // top row is the oldest line; the bottom row is the sample just taken
    always_comb begin
        for (int i = 0; i < LINES; i++) begin
            w_col[i] = w_ram_rd[LINE_W'(r_b_rot + LINE_W'(i))];
        end
        w_col[KSIZE-1] = r_b_px;
    end

    // ------------------------------------------------------------------
    // Stage C: chain of column cells (transposed sum) and center delay
    // ------------------------------------------------------------------
    logic                w_cell_en;
    logic [PSUM_W-1:0]   w_psum_in  [KSIZE];
    logic [PSUM_W-1:0]   w_psum_out [KSIZE];
    gbl_pkg::t_pix       r_ctr [HALF+1];

    assign w_cell_en    = w_adv && r_b_step;
    assign w_psum_in[0] = '0;

    for (genvar k = 0; k < KSIZE; k++) begin : g_cell
        if (k > 0) begin : g_link
            assign w_psum_in[k] = w_psum_out[k-1];
        end
        gbl_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_cell_en),
            .i_col  (w_col),
            .i_wgt  (gbl_pkg::KWEIGHT[k]),
            .i_psum (w_psum_in[k]),
            .o_psum (w_psum_out[k])
        );
    end

    // The window center is the middle sample of the column taken two steps ago:
    // exactly the pixel at the current result position, used in the border.
    always_ff @(posedge i_clk) begin
        if (w_cell_en) begin
            r_ctr[0] <= w_col[HALF];
            for (int i = 1; i <= HALF; i++) begin
                r_ctr[i] <= r_ctr[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage D: divide by 159 through a reciprocal multiply, pick border copy
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] w_prod;

    assign w_prod = PROD_W'(w_psum_out[KSIZE-1]) * PROD_W'(gbl_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_res.last <= r_c_last;
            r_d_res.pix  <= r_c_border ? r_ctr[HALF] :
                            w_prod[gbl_pkg::RECIP_SHIFT +: gbl_pkg::PIX_W];
        end
    end

    // ------------------------------------------------------------------
    // Output buffer
    // ------------------------------------------------------------------
    gbl_pkg::t_res q_data;

    gbl_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_d_valid && !q_full),
        .i_data  (r_d_res),
        .o_full  (q_full),
        .o_valid (m_axis_tvalid),
        .o_data  (q_data),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = q_data.pix;
    assign m_axis_tlast = q_data.last;

endmodule

FILE: bench/blur_tb_pkg.sv
`timescale 1ns / 100ps
// Bench-side codes for the 5x5 blur testbench: beat kinds, register addresses, size clamp.
// Depends on gbl_pkg for the kernel size and the port widths.
package blur_tb_pkg;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef enum logic [gbl_pkg::APB_AW-1:0] {
        ADDR_WIDTH  = 3'd0,
        ADDR_HEIGHT = 3'd4
    } t_cfg_addr;

    // Size the block actually uses for a written register value.
    function automatic int clamp_dim(input logic [gbl_pkg::CFG_W-1:0] v, input int hi);
        int r;
        r = int'(v);
        if (r < gbl_pkg::KSIZE) begin
            r = gbl_pkg::KSIZE;
        end else if (r > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

FILE: bench/blur_checker.sv
`timescale 1ns / 100ps
// Stream checker for gaussian_blur_5x5: tracks register writes, predicts every blurred
// pixel from the accepted input beats and compares it with the output stream.
// Depends on gbl_pkg and blur_tb_pkg.
module blur_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [7:0]                  i_in_data,
    input  logic [0:0]                  i_in_user,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [7:0]                  i_out_data,
    input  logic                        i_out_last,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [gbl_pkg::APB_AW-1:0]  i_paddr,
    input  logic [gbl_pkg::APB_DW-1:0]  i_pwdata,
    output int                          o_pending,
    output int                          o_fail_count,
    output int                          o_result_count,
    output int                          o_frame_count
);
    import gbl_pkg::*;
    import blur_tb_pkg::*;

    localparam int KERNEL_SUM  = 159;
    localparam int PRINT_LIMIT = 30;
    localparam int unsigned GAUSS [KSIZE][KSIZE] = '{
        '{2, 4,  5,  4,  2},
        '{4, 9,  12, 9,  4},
        '{5, 12, 15, 12, 5},
        '{4, 9,  12, 9,  4},
        '{2, 4,  5,  4,  2}
    };

    logic [7:0]       line_mem [LINES][MAX_WIDTH];
    logic [7:0]       win [KSIZE][KSIZE];
    logic [10:0]      col_pos;
    logic [11:0]      row_pos;
    logic [21:0]      out_pos;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    t_res             pending_pixels [$];
    int               fail_total;
    int               result_total;
    int               frame_total;

    task automatic report_mismatch(input string what);
        if (fail_total < PRINT_LIMIT) begin
            $display("%0t: mismatch: %s", $time, what);
        end
        fail_total++;
    endtask

    task automatic reset_state();
        foreach (win[i, j]) win[i][j] = '0;
        foreach (line_mem[i, j]) line_mem[i][j] = '0;
        col_pos    = '0;
        row_pos    = '0;
        out_pos    = '0;
        width_reg  = CFG_W'(RESET_WIDTH);
        height_reg = CFG_W'(RESET_HEIGHT);
        pending_pixels.delete();
    endtask

    // A size write restarts the frame.
    task automatic apply_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        if (addr == ADDR_WIDTH) begin
            width_reg = data[CFG_W-1:0];
        end else if (addr == ADDR_HEIGHT) begin
            height_reg = data[CFG_W-1:0];
        end else begin
            return;
        end
        col_pos = '0;
        row_pos = '0;
        out_pos = '0;
    endtask

    // Produce the pixel at out_pos: copied inside the two-pixel frame, blurred elsewhere.
    task automatic emit_pixel(output t_res r);
        int w, h, total, rr, cc, sum, nxt;
        w     = clamp_dim(width_reg, MAX_WIDTH);
        h     = clamp_dim(height_reg, MAX_HEIGHT);
        total = w * h;
        rr    = int'(out_pos) / w;
        cc    = int'(out_pos) % w;
        if (rr < HALF || rr >= h - HALF || cc < HALF || cc >= w - HALF) begin
            r.pix = line_mem[rr % LINES][cc];
        end else begin
            sum = 0;
            for (int i = 0; i < KSIZE; i++) begin
                for (int j = 0; j < KSIZE; j++) begin
                    sum += GAUSS[i][j] * int'(win[i][j]);
                end
            end
            r.pix = 8'(sum / KERNEL_SUM);
        end
        nxt    = int'(out_pos) + 1;
        r.last = (nxt == total);
        if (nxt >= total) begin
            col_pos = '0;
            row_pos = '0;
            out_pos = '0;
        end else begin
            out_pos = 22'(nxt);
        end
    endtask

    // Advance the window and line store by one input beat; report whether a pixel is due.
    task automatic blur_step(input logic kind, input logic [7:0] pix,
                             output bit due, output t_res r);
        int w, h, lag, nc, received;
        w   = clamp_dim(width_reg, MAX_WIDTH);
        h   = clamp_dim(height_reg, MAX_HEIGHT);
        lag = HALF * (w + 1);
        due = 1'b0;
        r   = '0;
        // whole frame in: any beat pushes out the next pixel of the tail
        if (int'(row_pos) >= h) begin
            emit_pixel(r);
            due = 1'b1;
            return;
        end
        if (kind == KIND_DRAIN) begin
            return;
        end
        for (int i = 0; i < KSIZE; i++) begin
            for (int j = 0; j < KSIZE - 1; j++) begin
                win[i][j] = win[i][j + 1];
            end
        end
        for (int i = 0; i < LINES; i++) begin
            win[i][KSIZE - 1] = line_mem[(int'(row_pos) + i) % LINES][col_pos];
        end
        win[KSIZE - 1][KSIZE - 1] = pix;
        line_mem[int'(row_pos) % LINES][col_pos] = pix;
        nc = int'(col_pos) + 1;
        if (nc >= w) begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end else begin
            col_pos = 11'(nc);
        end
        received = int'(row_pos) * w + int'(col_pos);
        if (received > int'(out_pos) + lag) begin
            emit_pixel(r);
            due = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_res want;
        t_res seen;
        bit   made;
        if (!i_rst_n) begin
            reset_state();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                apply_write(i_paddr, i_pwdata);
            end
            if (i_in_valid && i_in_ready) begin
                blur_step(i_in_user[0], i_in_data, made, want);
                if (made) begin
                    pending_pixels.push_back(want);
                end
            end
            if (i_out_valid && i_out_ready) begin
                seen.pix  = i_out_data;
                seen.last = i_out_last;
                if (pending_pixels.size() == 0) begin
                    report_mismatch($sformatf("result %0d with nothing pending (pixel %0d last %0b)",
                                              result_total, seen.pix, seen.last));
                end else begin
                    want = pending_pixels.pop_front();
                    if (seen.pix !== want.pix) begin
                        report_mismatch($sformatf("result %0d pixel %0d, expected %0d",
                                                  result_total, seen.pix, want.pix));
                    end
                    if (seen.last !== want.last) begin
                        report_mismatch($sformatf("result %0d last %0b, expected %0b",
                                                  result_total, seen.last, want.last));
                    end
                    if (want.last) begin
                        frame_total++;
                    end
                end
                result_total++;
            end
        end
        o_pending      <= pending_pixels.size();
        o_fail_count   <= fail_total;
        o_result_count <= result_total;
        o_frame_count  <= frame_total;
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Top of the gaussian_blur_5x5 testbench: clock, reset, stream and APB stimulus, verdict.
// Depends on gbl_pkg, blur_tb_pkg, blur_checker and the block itself.
module testbench;
    import gbl_pkg::*;
    import blur_tb_pkg::*;

    localparam int SETTLE       = 8;       // margin past the block's output latency
    localparam int HOLD_CYCLES  = 300;     // long output hold, fills the block up
    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_LIMIT  = 200000;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                s_axis_tvalid  = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata   = '0;   // [7:0] pixel_in
    logic [0:0]          s_axis_tuser   = '0;   // [0] kind (1 = drain beat)
    logic                m_axis_tvalid;
    logic                m_axis_tready  = 1'b0;
    logic [7:0]          m_axis_tdata;          // [7:0] pixel_out
    logic                m_axis_tlast;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [APB_AW-1:0]   paddr          = '0;
    logic [APB_DW-1:0]   pwdata         = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int   pending;
    int   fail_count;
    int   result_count;
    int   frame_count;

    // stimulus bookkeeping
    logic quiet    = 1'b0;   // no idling on either side once set
    logic hold_req = 1'b0;   // ask the sink for one long hold
    int   cur_w    = RESET_WIDTH;
    int   cur_h    = RESET_HEIGHT;
    int   beats_sent;
    int   items_sent;
    int   cfg_writes;
    int   guard;

    always #5 i_clk = ~i_clk;

    gaussian_blur_5x5 u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    blur_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .i_in_ready     (s_axis_tready),
        .i_in_data      (s_axis_tdata),
        .i_in_user      (s_axis_tuser),
        .i_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .i_out_data     (m_axis_tdata),
        .i_out_last     (m_axis_tlast),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_result_count (result_count),
        .o_frame_count  (frame_count)
    );

    // Offer one beat and hold it until the block takes it. Valid stays high afterwards
    // so that back-to-back beats need no second assignment in the same step.
    task automatic send_beat(input logic kind, input logic [7:0] pix);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
    endtask

    // Drop valid and wait until every predicted pixel is out, plus the block's latency.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register lands when pready is seen high.
    // Upper data bits are random: only the low 12 bits carry the size.
    task automatic write_reg(input t_cfg_addr addr, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {(APB_DW - CFG_W)'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (addr == ADDR_WIDTH) begin
            cur_w = clamp_dim(value, MAX_WIDTH);
        end else begin
            cur_h = clamp_dim(value, MAX_HEIGHT);
        end
        cfg_writes++;
    endtask

    task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        settle();
        write_reg(ADDR_WIDTH, w);
        write_reg(ADDR_HEIGHT, h);
    endtask

    // Mostly small frames; some below the minimum, a few wider ones.
    function automatic logic [CFG_W-1:0] pick_width();
        case ($urandom_range(0, 7))
            0:       return CFG_W'($urandom_range(0, 4));
            1:       return CFG_W'($urandom_range(20, 40));
            default: return CFG_W'($urandom_range(5, 12));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_height();
        if ($urandom_range(0, 7) == 0) begin
            return CFG_W'($urandom_range(0, 4));
        end
        return CFG_W'($urandom_range(5, 9));
    endfunction

    // Image pixels with extremes mixed in; noisy frames scatter early drain beats,
    // which the block must ignore.
    task automatic send_pixels(input int n, input bit noisy);
        logic [7:0] px;
        for (int k = 0; k < n; k++) begin
            if (noisy && $urandom_range(0, 11) == 0) begin
                send_beat(KIND_DRAIN, 8'($urandom()));
            end
            case ($urandom_range(0, 9))
                0:       px = 8'h00;
                1:       px = 8'hFF;
                default: px = 8'($urandom());
            endcase
            send_beat(KIND_PIXEL, px);
            items_sent++;
        end
    endtask

    // Flush the last 2*width+2 results; some flush beats are surplus pixels.
    task automatic send_tail();
        for (int k = 0; k < 2 * cur_w + 2; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_beat(KIND_PIXEL, 8'($urandom()));
            end else begin
                send_beat(KIND_DRAIN, 8'($urandom()));
            end
            items_sent++;
        end
    endtask

    task automatic full_frame(input bit noisy);
        send_pixels(cur_w * cur_h, noisy);
        send_tail();
    endtask

    // Sink side: random ready runs and idle bursts, one long hold on request,
    // always ready in the quiet tail of the run.
    initial begin : sink_side
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Drain beats before any image: nothing happens.
        send_beat(KIND_DRAIN, 8'hFF);
        send_beat(KIND_DRAIN, 8'h00);

        // Sizes below the minimum clamp to 5x5. Bright frame with a dark center, so the
        // one blurred pixel sees both pixel extremes.
        configure(12'd3, 12'd0);
        for (int k = 0; k < 25; k++) begin
            send_beat(KIND_PIXEL, (k == 12) ? 8'h00 : 8'hFF);
        end
        // tail with surplus pixels among the drain beats
        for (int k = 0; k < 12; k++) begin
            send_beat((k % 4 == 1) ? KIND_PIXEL : KIND_DRAIN, 8'($urandom()));
        end

        // Back pressure: hold the output long while beats keep coming.
        configure(12'd6, 12'd12);
        hold_req <= 1'b1;
        full_frame(1'b0);

        // Tallest clamped height, aborted part way by the next size write.
        configure(12'd5, 12'hFFF);
        send_pixels(40, 1'b1);
        configure(pick_width(), pick_height());

        // Random part: new sizes, single-register writes, back-to-back frames,
        // aborted frames and stray drain beats between frames.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    configure(pick_width(), pick_height());
                    full_frame(1'b1);
                end
                2: begin
                    full_frame(1'b1);
                end
                3: begin
                    send_pixels($urandom_range(1, cur_w * cur_h - 1), 1'b1);
                    configure(pick_width(), pick_height());
                end
                4: begin
                    settle();
                    if ($urandom_range(0, 1) == 0) begin
                        write_reg(ADDR_WIDTH, pick_width());
                    end else begin
                        write_reg(ADDR_HEIGHT, pick_height());
                    end
                    full_frame(1'b1);
                end
                default: begin
                    repeat ($urandom_range(1, 3)) send_beat(KIND_DRAIN, 8'($urandom()));
                    full_frame(1'b0);
                end
            endcase
        end

        // Quiet tail: widest clamped frame with no idling on either side.
        quiet <= 1'b1;
        configure(12'hFFF, 12'd5);
        full_frame(1'b0);

        // Wait out every pending pixel, bounded.
        s_axis_tvalid <= 1'b0;
        guard = 0;
        @(posedge i_clk);
        while (pending != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE) @(posedge i_clk);

        $display("run: %0d input beats, %0d register writes, %0d pixels out in %0d frames",
                 beats_sent, cfg_writes, result_count, frame_count);
        $display("run: sizes from clamped 5x5 to 2048 wide, aborted frames, long output hold");
        if (pending != 0) begin
            $display("%0d predicted pixels never came out", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin : watchdog
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
